// ===== hdl/quaternion_nlerp_to_rotation_matrix_unit_assert.svh =====
// Assertion macros used by the port-level checker of the quaternion matrix unit.
`ifndef QUATERNION_NLERP_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_NLERP_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is applied.
`define QNM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is applied.
`define QNM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define QNM_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qnm_pkg.sv =====
// Types and constants shared by the quaternion matrix unit.
`timescale 1ns / 1ps
package qnm_pkg;

    localparam int CW      = 25;  // rounded blended component, signed
    localparam int PW      = 50;  // component product, signed
    localparam int LW      = 49;  // squared length, unsigned
    localparam int NW      = 64;  // dividend of the ratio
    localparam int DW      = 50;  // divisor, twice the length
    localparam int QBITS   = 15;  // quotient bits
    localparam int NLANE   = 9;   // matrix entries
    localparam int ONE_Q14 = 16384;

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic [NW-1:0]        t_dvd;
    typedef logic [QBITS-1:0]     t_quo;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] start_w;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
        logic signed [15:0] end_w;
        logic [15:0]        blend;
    } t_in;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic valid;
        logic degenerate;
    } t_ctl;

endpackage

// ===== hdl/qnm_blend.sv =====
// Hemisphere fix, linear blend and rounding of the two quaternions (two stages).
`timescale 1ns / 1ps
module qnm_blend import qnm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_valid,
    output t_comp o_c [4]
);

    logic signed [15:0] w_a [4];
    logic signed [15:0] w_b [4];
    logic [16:0]        w_g;

    logic signed [32:0] r_ag [4];
    logic signed [32:0] r_bf [4];
    logic signed [31:0] r_ab [4];
    logic               r_v1;
    t_comp              r_c  [4];
    logic               r_v2;

    logic signed [33:0] w_dot;
    logic               w_neg;
    logic signed [33:0] w_e  [4];
    logic signed [34:0] w_m  [4];
    logic signed [34:0] w_mr [4];

    assign w_a[0] = i_data.start_x;
    assign w_a[1] = i_data.start_y;
    assign w_a[2] = i_data.start_z;
    assign w_a[3] = i_data.start_w;
    assign w_b[0] = i_data.end_x;
    assign w_b[1] = i_data.end_y;
    assign w_b[2] = i_data.end_z;
    assign w_b[3] = i_data.end_w;
    assign w_g    = 17'd65536 - {1'b0, i_data.blend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_ag[i] <= 33'(w_a[i]) * $signed(33'(w_g));
                r_bf[i] <= 33'(w_b[i]) * $signed(33'(i_data.blend));
                r_ab[i] <= 32'(w_a[i]) * 32'(w_b[i]);
            end
        end
    end

    // The second quaternion is flipped when the 4-D dot product is negative.
    always_comb begin
        w_dot = 34'(r_ab[0]) + 34'(r_ab[1]) + 34'(r_ab[2]) + 34'(r_ab[3]);
        w_neg = w_dot[33];
        for (int i = 0; i < 4; i++) begin
            w_e[i]  = w_neg ? -34'(r_bf[i]) : 34'(r_bf[i]);
            w_m[i]  = 35'(r_ag[i]) + 35'(w_e[i]);
            w_mr[i] = (w_m[i] + 35'sd128) >>> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_c[i] <= w_mr[i][CW-1:0];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_c     = r_c;

endmodule

// ===== hdl/qnm_prod.sv =====
// Component products, squared length and the nine matrix numerators (three stages).
`timescale 1ns / 1ps
module qnm_prod import qnm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_comp            i_c   [4],
    output t_ctl             o_ctl,
    output t_dvd             o_n   [NLANE],
    output logic [NLANE-1:0] o_sign,
    output logic [DW-1:0]    o_den
);

    t_prod r_xx, r_yy, r_zz, r_ww, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    logic  r_v3;

    logic signed [51:0]    w_len;
    logic signed [51:0]    w_num [NLANE];
    logic signed [PW-1:0]  r_num [NLANE];
    logic [LW-1:0]         r_len;
    logic                  r_v4;

    logic [PW-1:0]         w_abs [NLANE];
    t_dvd                  r_n   [NLANE];
    logic [NLANE-1:0]      r_sign;
    logic [DW-1:0]         r_den;
    t_ctl                  r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_ctl     <= '0;
        end else if (i_en) begin
            r_v3            <= i_valid;
            r_v4            <= r_v3;
            r_ctl.valid     <= r_v4;
            r_ctl.degenerate <= (r_len == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= PW'(i_c[0]) * PW'(i_c[0]);
            r_yy <= PW'(i_c[1]) * PW'(i_c[1]);
            r_zz <= PW'(i_c[2]) * PW'(i_c[2]);
            r_ww <= PW'(i_c[3]) * PW'(i_c[3]);
            r_xy <= PW'(i_c[0]) * PW'(i_c[1]);
            r_zw <= PW'(i_c[2]) * PW'(i_c[3]);
            r_xz <= PW'(i_c[0]) * PW'(i_c[2]);
            r_yw <= PW'(i_c[1]) * PW'(i_c[3]);
            r_yz <= PW'(i_c[1]) * PW'(i_c[2]);
            r_xw <= PW'(i_c[0]) * PW'(i_c[3]);
        end
    end

    // Numerators in row-major order; every one lies within plus or minus the length.
    always_comb begin
        w_len    = 52'(r_xx) + 52'(r_yy) + 52'(r_zz) + 52'(r_ww);
        w_num[0] = w_len - ((52'(r_yy) + 52'(r_zz)) <<< 1);
        w_num[1] = (52'(r_xy) - 52'(r_zw)) <<< 1;
        w_num[2] = (52'(r_xz) + 52'(r_yw)) <<< 1;
        w_num[3] = (52'(r_xy) + 52'(r_zw)) <<< 1;
        w_num[4] = w_len - ((52'(r_xx) + 52'(r_zz)) <<< 1);
        w_num[5] = (52'(r_yz) - 52'(r_xw)) <<< 1;
        w_num[6] = (52'(r_xz) - 52'(r_yw)) <<< 1;
        w_num[7] = (52'(r_yz) + 52'(r_xw)) <<< 1;
        w_num[8] = w_len - ((52'(r_xx) + 52'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= w_len[LW-1:0];
            for (int i = 0; i < NLANE; i++) begin
                r_num[i] <= w_num[i][PW-1:0];
            end
        end
    end

    // Dividend for round-half-away: magnitude times 2^15 plus the length, over twice the length.
    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            w_abs[i] = r_num[i][PW-1] ? PW'(-r_num[i]) : PW'(r_num[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= {r_len, 1'b0};
            for (int i = 0; i < NLANE; i++) begin
                r_sign[i] <= r_num[i][PW-1];
                r_n[i]    <= {w_abs[i][LW-1:0], {QBITS{1'b0}}} + NW'(r_len);
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_n    = r_n;
    assign o_sign = r_sign;
    assign o_den  = r_den;

endmodule

// ===== hdl/qnm_div.sv =====
// Nine-lane restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module qnm_div import qnm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  t_dvd             i_n    [NLANE],
    input  logic [NLANE-1:0] i_sign,
    input  logic [DW-1:0]    i_den,
    output t_ctl             o_ctl,
    output t_quo             o_q    [NLANE],
    output logic [NLANE-1:0] o_sign
);

    t_dvd             r_rem [QBITS][NLANE];
    t_quo             r_q   [QBITS][NLANE];
    logic [DW-1:0]    r_den [QBITS];
    logic [NLANE-1:0] r_sg  [QBITS];
    t_ctl             r_ct  [QBITS];

    t_dvd             w_rem [QBITS][NLANE];
    t_quo             w_q   [QBITS][NLANE];
    logic [DW-1:0]    w_den [QBITS];
    logic [NLANE-1:0] w_sg  [QBITS];
    t_ctl             w_ct  [QBITS];

    for (genvar s = 0; s < QBITS; s++) begin : g_stage
        localparam int K = QBITS - 1 - s;
        t_dvd w_sub [NLANE];

        if (s == 0) begin : g_first
            assign w_den[s] = i_den;
            assign w_sg[s]  = i_sign;
            assign w_ct[s]  = i_ctl;
            for (genvar l = 0; l < NLANE; l++) begin : g_l
                assign w_rem[s][l] = i_n[l];
                assign w_q[s][l]   = '0;
            end
        end else begin : g_next
            assign w_den[s] = r_den[s-1];
            assign w_sg[s]  = r_sg[s-1];
            assign w_ct[s]  = r_ct[s-1];
            for (genvar l = 0; l < NLANE; l++) begin : g_l
                assign w_rem[s][l] = r_rem[s-1][l];
                assign w_q[s][l]   = r_q[s-1][l];
            end
        end

        for (genvar l = 0; l < NLANE; l++) begin : g_lane
            assign w_sub[l] = NW'(w_den[s]) << K;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ct[s] <= '0;
            end else if (i_en) begin
                r_ct[s] <= w_ct[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= w_den[s];
                r_sg[s]  <= w_sg[s];
                for (int l = 0; l < NLANE; l++) begin
                    if (w_rem[s][l] >= w_sub[l]) begin
                        r_rem[s][l] <= w_rem[s][l] - w_sub[l];
                        r_q[s][l]   <= w_q[s][l] | (t_quo'(1) << K);
                    end else begin
                        r_rem[s][l] <= w_rem[s][l];
                        r_q[s][l]   <= w_q[s][l];
                    end
                end
            end
        end
    end

    assign o_ctl  = r_ct[QBITS-1];
    assign o_q    = r_q[QBITS-1];
    assign o_sign = r_sg[QBITS-1];

endmodule

// ===== hdl/quaternion_nlerp_to_rotation_matrix_unit.sv =====
// Top level of the quaternion blend to rotation matrix unit.
`timescale 1ns / 1ps
// Usage
// -----
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one pose per transaction:
// two quaternions in signed Q1.15 and a blend fraction in unsigned Q0.16.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries the nine Q2.14
// entries of the normalized rotation matrix and a degenerate flag. When the blended
// quaternion has zero length the identity matrix is sent with the flag set.
// Every accepted transaction yields exactly one result transaction, in order.
// The path holds two blend stages, three product stages, fifteen divider
// stages (one quotient bit each) and the output register. Throughput is one
// transaction per cycle while the receiver takes results.
// The whole pipeline advances together whenever the output register is empty or
// its result is being taken. When the receiver stalls with a result waiting, every
// stage holds, o_in_ready drops, and nothing is lost or repeated.
// Reset is synchronous, active low, and clears all valid bits; the block is ready
// in the first cycle after reset.
module quaternion_nlerp_to_rotation_matrix_unit import qnm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic             w_en;
    logic             w_bl_valid;
    t_comp            w_c     [4];
    t_ctl             w_pr_ctl;
    t_dvd             w_n     [NLANE];
    logic [NLANE-1:0] w_pr_sign;
    logic [DW-1:0]    w_den;
    t_ctl             w_dv_ctl;
    t_quo             w_q     [NLANE];
    logic [NLANE-1:0] w_dv_sign;

    logic signed [15:0] w_ent [NLANE];
    t_out               n_out;
    t_out               r_out;
    logic               r_out_valid;

    // One enable for the whole pipeline: move when the output slot is free or draining.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    qnm_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_bl_valid),
        .o_c     (w_c)
    );

    qnm_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_bl_valid),
        .i_c     (w_c),
        .o_ctl   (w_pr_ctl),
        .o_n     (w_n),
        .o_sign  (w_pr_sign),
        .o_den   (w_den)
    );

    qnm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_pr_ctl),
        .i_n     (w_n),
        .i_sign  (w_pr_sign),
        .i_den   (w_den),
        .o_ctl   (w_dv_ctl),
        .o_q     (w_q),
        .o_sign  (w_dv_sign)
    );

    // Saturate each quotient to one, restore its sign, and pick the identity for a
    // zero-length blend. Diagonal entries are lanes 0, 4 and 8.
    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            if (w_dv_ctl.degenerate) begin
                w_ent[i] = (i % 4 == 0) ? 16'(ONE_Q14) : 16'sd0;
            end else if (w_q[i] > t_quo'(ONE_Q14)) begin
                w_ent[i] = w_dv_sign[i] ? -16'(ONE_Q14) : 16'(ONE_Q14);
            end else begin
                w_ent[i] = w_dv_sign[i] ? -$signed(16'(w_q[i])) : $signed(16'(w_q[i]));
            end
        end
        n_out.r00        = w_ent[0];
        n_out.r01        = w_ent[1];
        n_out.r02        = w_ent[2];
        n_out.r10        = w_ent[3];
        n_out.r11        = w_ent[4];
        n_out.r12        = w_ent[5];
        n_out.r20        = w_ent[6];
        n_out.r21        = w_ent[7];
        n_out.r22        = w_ent[8];
        n_out.degenerate = w_dv_ctl.degenerate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/qnm_checker.sv =====
// Port-level checks of the quaternion matrix unit and their binding.
`timescale 1ns / 1ps
`include "quaternion_nlerp_to_rotation_matrix_unit_assert.svh"
module qnm_checker import qnm_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    `QNM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    `QNM_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready, "input not ready with empty output")

    `QNM_ASSERT_NOW(a_identity, o_out_valid && o_out_data.degenerate, o_out_data.r00 == 16'sd16384 && o_out_data.r11 == 16'sd16384 && o_out_data.r22 == 16'sd16384 && o_out_data.r01 == 16'sd0 && o_out_data.r12 == 16'sd0 && o_out_data.r20 == 16'sd0, "degenerate result is not identity")

    `QNM_ASSERT_NOW(a_range, o_out_valid, o_out_data.r00 <= 16'sd16384 && o_out_data.r00 >= -16'sd16384 && o_out_data.r11 <= 16'sd16384 && o_out_data.r11 >= -16'sd16384 && o_out_data.r22 <= 16'sd16384 && o_out_data.r22 >= -16'sd16384, "diagonal entry out of range")

    `QNM_ASSERT_RST(a_reset_clears, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind quaternion_nlerp_to_rotation_matrix_unit qnm_checker u_qnm_checker (.*);
